// ===== design/krle_pkg.sv =====
// Shared types and constants for the key repeat and long-press engine.
package krle_pkg;

    localparam int NUM_KEYS_DEF    = 4;
    localparam int TIMER_WIDTH_DEF = 32;
    localparam int KEY_W           = 2;
    localparam int CFG_W           = 32;
    localparam int TICK_W          = 32;
    localparam int ADDR_W          = 4;

    localparam logic [CFG_W-1:0] REPEAT_RESET  = 32'd100000000;
    localparam logic [CFG_W-1:0] LONG_RESET    = 32'd500000000;
    localparam logic [CFG_W-1:0] GUARD_RESET   = 32'd10000000;

    localparam logic [1:0] REG_REPEAT = 2'd0;
    localparam logic [1:0] REG_LONG   = 2'd1;
    localparam logic [1:0] REG_GUARD  = 2'd2;

    localparam int KEY_VDOWN = 0;
    localparam int KEY_VUP   = 1;
    localparam int KEY_POWER = 2;
    localparam int KEY_SPEC  = 3;

    typedef logic [2:0] ev_code_t;

    localparam ev_code_t EV_DOWN   = 3'd0;
    localparam ev_code_t EV_UP     = 3'd1;
    localparam ev_code_t EV_ENTER  = 3'd2;
    localparam ev_code_t EV_ESCAPE = 3'd3;
    localparam ev_code_t EV_RIGHT  = 3'd4;
    localparam ev_code_t EV_LEFT   = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] repeat_ns;
        logic [CFG_W-1:0] long_ns;
        logic [CFG_W-1:0] guard_ns;
    } cfg_t;

    typedef struct packed {
        logic     valid;
        ev_code_t code;
    } lane_event_t;

    function automatic ev_code_t own_code(input int key);
        ev_code_t c;
        case (key)
            KEY_VDOWN: c = EV_DOWN;
            KEY_VUP:   c = EV_UP;
            KEY_POWER: c = EV_ENTER;
            default:   c = EV_ESCAPE;
        endcase
        return c;
    endfunction

endpackage

// ===== design/krle_lane.sv =====
// One key lane: saturating hold timer and press, repeat and release machine.
module krle_lane
    import krle_pkg::*;
#(
    parameter int KEY_IDX     = 0,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              pressed,
    input  logic [TICK_W-1:0] tick,
    input  cfg_t              cfg,
    input  logic              raw_power,
    input  logic              raw_vdown,
    input  logic              raw_vup,
    output lane_event_t       ev
);

    localparam int CW = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;
    localparam logic [CW:0] TMAX = {{(CW + 1 - TIMER_WIDTH){1'b0}}, {TIMER_WIDTH{1'b1}}};

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_PENDING  = 2'd2
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic                   rep_reg, rep_next;
    logic                   lp_reg, lp_next;

    logic [CW:0]            sum;
    logic [TIMER_WIDTH-1:0] sat;
    logic                   ge_rep, ge_long, ge_guard;

    always_comb
    begin
        sum = (CW + 1)'(timer_reg) + (CW + 1)'(tick);
        sat = (sum > TMAX) ? TIMER_WIDTH'(TMAX) : sum[TIMER_WIDTH-1:0];
        ge_rep   = CW'(sat) >= CW'(cfg.repeat_ns);
        ge_long  = CW'(sat) >= CW'(cfg.long_ns);
        ge_guard = CW'(sat) >= CW'(cfg.guard_ns);
    end

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = sat;
        rep_next   = rep_reg;
        lp_next    = lp_reg;
        ev.valid   = 1'b0;
        ev.code    = own_code(KEY_IDX);
        unique case (phase_reg)
            PH_RELEASED:
            begin
                if (pressed)
                begin
                    timer_next = '0;
                    phase_next = PH_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                if (pressed)
                begin
                    if (rep_reg && ge_rep)
                    begin
                        ev.valid   = 1'b1;
                        timer_next = '0;
                    end
                    else if (!lp_reg && ge_long)
                    begin
                        if (KEY_IDX == KEY_POWER)
                        begin
                            ev.valid = 1'b1;
                            if (raw_vdown)
                                ev.code = EV_RIGHT;
                            else if (raw_vup)
                                ev.code = EV_LEFT;
                            else
                                ev.code = EV_ESCAPE;
                        end
                        else if (!raw_power)
                        begin
                            ev.valid   = 1'b1;
                            timer_next = '0;
                            rep_next   = 1'b1;
                        end
                        lp_next = 1'b1;
                    end
                end
                else
                begin
                    if (!lp_reg)
                    begin
                        ev.valid   = 1'b1;
                        phase_next = PH_PENDING;
                    end
                    else if (ge_guard)
                    begin
                        timer_next = '0;
                        rep_next   = 1'b0;
                        lp_next    = 1'b0;
                        phase_next = PH_RELEASED;
                    end
                end
            end
            default:
            begin
                timer_next = '0;
                rep_next   = 1'b0;
                lp_next    = 1'b0;
                phase_next = PH_RELEASED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RELEASED;
            timer_reg <= '0;
            rep_reg   <= 1'b0;
            lp_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            rep_reg   <= rep_next;
            lp_reg    <= lp_next;
        end
    end

endmodule

// ===== design/krle_merge.sv =====
// Event merge stage: holds the events of one tick and sends them in key order.
module krle_merge
    import krle_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lane_event_t      ev [NUM_KEYS],
    input  logic             out_stall,
    output logic             out_valid,
    output ev_code_t         event_code,
    output logic [KEY_W-1:0] source_key,
    output logic             last_event,
    output logic             can_accept
);

    logic [NUM_KEYS-1:0] valid_reg, valid_next;
    ev_code_t            code_reg [NUM_KEYS];
    logic [KEY_W-1:0]    sel;
    logic [NUM_KEYS-1:0] sel_bit;
    logic                out_fire;

    always_comb
    begin
        sel = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (valid_reg[k])
                sel = KEY_W'(k);
        end
        sel_bit    = NUM_KEYS'(1) << sel;
        out_valid  = |valid_reg;
        event_code = code_reg[sel];
        source_key = sel;
        last_event = (valid_reg & ~sel_bit) == '0;
        out_fire   = out_valid && !out_stall;
        can_accept = !out_valid || (out_fire && last_event);
        valid_next = valid_reg;
        if (out_fire)
            valid_next = valid_reg & ~sel_bit;
        if (load)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                valid_next[k] = ev[k].valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                code_reg[k] <= ev[k].code;
        end
    end

endmodule

// ===== design/key_repeat_longpress_engine_core.sv =====
// Top level of the key repeat and long-press engine: config registers, key lanes, merge.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  key_pressed_mask, tick_ns
// output    out        out_valid/out_stall  event_code, source_key, last_event
// config    in         APB write/read       paddr, pwdata, prdata
//
// All key lanes update in the cycle a tick item is accepted; their events land in the
// merge stage, which sends one event item per cycle in key order while out_stall is low.
// A tick yields at most NUM_KEYS events; a tick with none leaves the merge stage empty.
// The next tick is accepted in the cycle its predecessor's last event leaves.
// Reset clears all key state and loads the register defaults.
// A stalled output holds its event and the input stalls until the last event leaves.
module key_repeat_longpress_engine_core
    import krle_pkg::*;
#(
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        key_pressed_mask,
    input  logic [TICK_W-1:0] tick_ns,
    output logic              out_valid,
    input  logic              out_stall,
    output ev_code_t          event_code,
    output logic [KEY_W-1:0]  source_key,
    output logic              last_event
);

    cfg_t        cfg_reg;
    logic        raw_power_reg;
    logic        can_accept;
    logic        in_fire;
    logic        out_fire;
    logic        cfg_write;
    logic [1:0]  cfg_idx;
    lane_event_t lane_ev [NUM_KEYS];

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_stall  = !can_accept;
    assign in_fire   = in_valid && can_accept;
    assign out_fire  = out_valid && !out_stall;

    always_comb
    begin
        unique case (cfg_idx)
            REG_REPEAT: prdata = cfg_reg.repeat_ns;
            REG_LONG:   prdata = cfg_reg.long_ns;
            REG_GUARD:  prdata = cfg_reg.guard_ns;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_ns <= REPEAT_RESET;
            cfg_reg.long_ns   <= LONG_RESET;
            cfg_reg.guard_ns  <= GUARD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_REPEAT: cfg_reg.repeat_ns <= pwdata;
                REG_LONG:   cfg_reg.long_ns   <= pwdata;
                REG_GUARD:  cfg_reg.guard_ns  <= pwdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            raw_power_reg <= 1'b0;
        else if (in_fire)
            raw_power_reg <= key_pressed_mask[KEY_POWER];
    end

    // Volume keys see the power bit of the previous tick, the special key this tick's.
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        krle_lane #(
            .KEY_IDX     (k),
            .TIMER_WIDTH (TIMER_WIDTH)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .accept    (in_fire),
            .pressed   (key_pressed_mask[k]),
            .tick      (tick_ns),
            .cfg       (cfg_reg),
            .raw_power ((k == KEY_SPEC) ? key_pressed_mask[KEY_POWER] : raw_power_reg),
            .raw_vdown (key_pressed_mask[KEY_VDOWN]),
            .raw_vup   (key_pressed_mask[KEY_VUP]),
            .ev        (lane_ev[k])
        );
    end

    krle_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire),
        .ev         (lane_ev),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .event_code (event_code),
        .source_key (source_key),
        .last_event (last_event),
        .can_accept (can_accept)
    );

    // A new tick is taken only once every pending event is gone or leaving.
    a_accept_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!out_valid || (out_fire && last_event)))
        else $error("tick accepted while events were still pending");

    // After the last event of a tick leaves, nothing remains unless a new tick came in.
    a_empty_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_event && !in_fire) |=> !out_valid)
        else $error("event left over after last event");

    // Events of one tick leave in rising key order with no gap in the stream.
    a_key_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !last_event) |=> (out_valid && (source_key > $past(source_key))))
        else $error("events of a tick out of key order");

endmodule
